### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// shared clocked assertion forms with asynchronous active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clk_i / rst_ni pair
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the substring match finder
// field widths, register indexes, stream packing and cell control
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 6;   // pattern_length register
  localparam int unsigned IDX_W      = 5;   // byte index into the 32 byte pattern
  localparam int unsigned START_W    = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PAT_WORDS  = 4;
  localparam int unsigned PAT_BITS   = PAT_WORDS * CFG_DATA_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MID_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MID_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH     = 3'd4;

  // stream packing
  localparam int unsigned IN_TDATA_W    = BYTE_W;
  localparam int unsigned OUT_FIELDS_W  = 1 + START_W + 1;
  localparam int unsigned OUT_TDATA_W   = 24;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int unsigned OUT_FOUND_BIT = 0;
  localparam int unsigned OUT_START_LSB = 1;
  localparam int unsigned OUT_OVF_BIT   = OUT_START_LSB + START_W;

  typedef struct packed {
    logic shift;   // item accepted, cell 0 takes the input byte, every other cell its neighbor's
    logic active;  // cell lies inside the current pattern length
  } smf_cell_ctrl_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic               position_overflow;
    logic               text_done;
  } smf_result_t;

endpackage

`default_nettype wire

### rtl/substring_match_finder.sv
// ----------------------------------------------------------------------------
// substring_match_finder: streaming pattern search over a byte stream
// a row of compare cells finds every match, overlaps included, of a
// configured pattern of 1 to MAX_PATTERN_BYTES bytes
// ----------------------------------------------------------------------------
// the result of an item is registered into the output register, or into the skid entry while the output stalls
// one item per cycle while s_axis_tready is high, the cell row shifting once per item
// a skid entry takes one more item while a result waits, then tready drops
// reset: pattern length 1, pattern bytes zero, cells zero, position zero
// no clearing pass, the block takes items right after reset
`default_nettype none

module substring_match_finder #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned MAX_TEXT_LENGTH   = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [smf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
  input  logic                              s_axis_tlast,   // end_of_text
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] match_found, [16:1] match_start, [17] position_overflow, [23:18] zero
  output logic [smf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,   // text_done
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [smf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [smf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import smf_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_TEXT_LENGTH + 1);

  // configuration registers
  logic [LEN_W-1:0]                      len_q;
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]  pat_q;
  logic [PAT_BITS-1:0]                   pat_flat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LENGTH:   len_q    <= cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_LOW:      pat_q[0] <= cfg_data_i;
        CFG_PATTERN_MID_LOW:  pat_q[1] <= cfg_data_i;
        CFG_PATTERN_MID_HIGH: pat_q[2] <= cfg_data_i;
        CFG_PATTERN_HIGH:     pat_q[3] <= cfg_data_i;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign pat_flat = pat_q;

  // length in use: zero acts as one, large values clamp to the cell count
  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] len_m1;

  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = len_q;
    end
  end

  assign len_m1 = IDX_W'(eff_len - LEN_W'(1));

  // handshake and skid stage state
  logic        in_acc;
  smf_result_t out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // compare row: cell 0 sees the incoming byte, cell k compares with
  // pattern byte len-1-k, so the row lines the pattern up with its last byte
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] chain_in;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] chain_q;
  logic [MAX_PATTERN_BYTES-1:0]             hit;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(k);
    smf_cell_ctrl_t   ctrl;
    logic [IDX_W-1:0] sel;

    if (k == 0) begin : g_head
      assign chain_in[k] = s_axis_tdata[BYTE_W-1:0];
    end else begin : g_link
      assign chain_in[k] = chain_q[k-1];
    end

    assign sel         = len_m1 - CellIdx;
    assign ctrl.shift  = in_acc;
    assign ctrl.active = (CellIdx <= len_m1);

    smf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (chain_in[k]),
      .pat_byte_i (pat_flat[sel*BYTE_W +: BYTE_W]),
      .byte_o     (chain_q[k]),
      .hit_o      (hit[k])
    );
  end

  // position inside the current text, saturates at the maximum length
  logic [POS_W-1:0] pos_q;
  logic             overflow;
  logic             long_enough;
  logic             found;

  assign overflow    = (pos_q == POS_W'(MAX_TEXT_LENGTH));
  // a match needs len bytes of this text, older texts never contribute
  assign long_enough = (pos_q >= POS_W'(len_m1));
  assign found       = (&hit) && !overflow && long_enough;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        pos_q <= '0;
      end else if (!overflow) begin
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    res.match_found       = found;
    res.match_start       = found ? (START_W'(pos_q) - START_W'(len_m1)) : '0;
    res.position_overflow = overflow;
    res.text_done         = s_axis_tlast;
  end

  // output register plus skid entry: a new item lands in the skid entry
  // when the output holds a result that is not taken this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.position_overflow,
                          out_q.match_start, out_q.match_found};
  assign m_axis_tlast  = out_q.text_done;

endmodule

`default_nettype wire

### rtl/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell: one cell of the compare row
// holds one recent text byte, passes it on and compares the incoming one
// ----------------------------------------------------------------------------
`default_nettype none

module smf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smf_pkg::smf_cell_ctrl_t       ctrl_i,
  input  logic [smf_pkg::BYTE_W-1:0]    byte_i,
  input  logic [smf_pkg::BYTE_W-1:0]    pat_byte_i,
  output logic [smf_pkg::BYTE_W-1:0]    byte_o,
  output logic                          hit_o
);
  import smf_pkg::*;

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // cells past the pattern end never block a match
  assign hit_o  = !ctrl_i.active || (byte_i == pat_byte_i);
  assign byte_o = byte_q;

endmodule

`default_nettype wire

### rtl/smf_checker.sv
// ----------------------------------------------------------------------------
// smf_checker: port level checks of the substring match finder
// watches the result stream and the input back-pressure over time
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [smf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast
);
  import smf_pkg::*;

  // a stalled result item holds
  `ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result item changed")

  // an overflowed position never reports a match
  `ASSERT_DEF(a_ovf_no_match, m_axis_tvalid && m_axis_tdata[OUT_OVF_BIT] |-> !m_axis_tdata[OUT_FOUND_BIT], "match reported after position overflow")

  // without a match the start index reads zero
  `ASSERT_DEF(a_start_zero, m_axis_tvalid && !m_axis_tdata[OUT_FOUND_BIT] |-> (m_axis_tdata[OUT_OVF_BIT-1:OUT_START_LSB] == '0), "start index set without a match")

  // back-pressure only while a result waits on the output
  `ASSERT_DEF(a_ready_low, !s_axis_tready |-> m_axis_tvalid, "input stalled with an empty output")

endmodule

bind substring_match_finder smf_checker u_smf_checker (.*);

`default_nettype wire
